FILE: hw/rtl/lds_pkg.sv
// Shared types and constants for the LOOK disk scheduler.
// Used by lds_ctrl, lds_datapath and look_disk_scheduler; no dependencies.
package lds_pkg;

  localparam int CylW     = 16;
  localparam int TotW     = 17;
  localparam int CfgW     = 17;
  localparam int CfgIdxW  = 2;
  localparam int OutDataW = 72;

  localparam logic [CfgIdxW-1:0] REG_CYL_COUNT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEAD_START = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HEAD_PREV  = 2'd2;

  localparam logic [CfgW-1:0] CylCountReset = 17'h10000;

  typedef struct packed {
    logic store;
    logic start;
    logic scan_clear;
    logic scan_run;
    logic emit;
    logic clear_batch;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic last_move;
  } sts_t;

endpackage

FILE: hw/rtl/lds_ctrl.sv
// Controller state machine of the LOOK disk scheduler.
// Depends on lds_pkg; drives lds_datapath through cmd_t, reads sts_t.
module lds_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  input  lds_pkg::sts_t sts,
  output lds_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.store = 1'b1;
          if (in_tlast) begin
            cmd.start      = 1'b1;
            cmd.scan_clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_move) begin
            cmd.clear_batch = 1'b1;
            state_nxt       = S_LOAD;
          end else begin
            cmd.scan_clear = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lds_datapath.sv
// Datapath of the LOOK disk scheduler: config registers, request memory,
// selection scan and output register. Depends on lds_pkg.
module lds_datapath #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lds_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [lds_pkg::CfgW-1:0]          cfg_wdata,
  input  logic [lds_pkg::CylW-1:0]          req_cyl,
  input  lds_pkg::cmd_t                     cmd,
  output lds_pkg::sts_t                     sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lds_pkg::OutDataW-1:0]      out_tdata,
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int PadW = lds_pkg::OutDataW - 3 * lds_pkg::CylW - lds_pkg::TotW;

  logic [lds_pkg::CfgW-1:0]  cyl_count_r;
  logic [lds_pkg::CylW-1:0]  head_start_r;
  logic [lds_pkg::CylW-1:0]  head_prev_r;

  logic [lds_pkg::CylW-1:0]  mem [MAX_REQUESTS];
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             done_r;
  logic [MAX_REQUESTS-1:0]   served_r;
  logic [lds_pkg::CylW-1:0]  head_r;
  logic [lds_pkg::TotW-1:0]  total_r;

  logic [CW-1:0]             scan_cnt_r;
  logic                      rd_v_r;
  logic [IW-1:0]             rd_idx_r;
  logic [lds_pkg::CylW-1:0]  rd_data_r;
  logic                      best_valid_r;
  logic [lds_pkg::CylW:0]    best_key_r;
  logic [IW-1:0]             best_idx_r;
  logic [lds_pkg::CylW-1:0]  best_val_r;

  logic                      out_valid_r;
  logic [lds_pkg::CylW-1:0]  from_r, to_r, dist_r;
  logic [lds_pkg::TotW-1:0]  tot_r;
  logic                      empty_r, final_r;

  logic                      req_ok;
  logic                      issue;
  logic                      up_first;
  logic                      rd_upper;
  logic [lds_pkg::CylW:0]    rd_key;
  logic                      take;
  logic                      empty_batch;
  logic [lds_pkg::CylW-1:0]  to_sel;
  logic [lds_pkg::CylW-1:0]  dist_sel;
  logic [lds_pkg::TotW-1:0]  total_sel;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyl_count_r  <= lds_pkg::CylCountReset;
      head_start_r <= '0;
      head_prev_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lds_pkg::REG_CYL_COUNT:  cyl_count_r  <= cfg_wdata;
        lds_pkg::REG_HEAD_START: head_start_r <= cfg_wdata[lds_pkg::CylW-1:0];
        lds_pkg::REG_HEAD_PREV:  head_prev_r  <= cfg_wdata[lds_pkg::CylW-1:0];
        default: ;
      endcase
    end
  end

  assign req_ok = ({1'b0, req_cyl} < cyl_count_r) && (count_r < CW'(MAX_REQUESTS));
  assign issue  = cmd.scan_run && (scan_cnt_r < count_r);

  // request memory
  always_ff @(posedge clk) begin
    if (cmd.store && req_ok) begin
      mem[count_r[IW-1:0]] <= req_cyl;
    end
    rd_data_r <= mem[scan_cnt_r[IW-1:0]];
  end

  // order key: first sweep group, then ascending or descending cylinder
  assign up_first = head_prev_r < head_start_r;
  assign rd_upper = rd_data_r >= head_start_r;
  assign rd_key   = {rd_upper ^ up_first, rd_upper ? rd_data_r : ~rd_data_r};
  assign take     = rd_v_r && !served_r[rd_idx_r] && (!best_valid_r || rd_key < best_key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      rd_v_r       <= 1'b0;
      best_valid_r <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_cnt_r   <= '0;
      rd_v_r       <= 1'b0;
      best_valid_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      if (issue) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      if (take) begin
        best_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= scan_cnt_r[IW-1:0];
    end
    if (take) begin
      best_key_r <= rd_key;
      best_idx_r <= rd_idx_r;
      best_val_r <= rd_data_r;
    end
  end

  // move computation
  assign empty_batch = (count_r == '0);
  assign to_sel      = empty_batch ? head_start_r : best_val_r;
  assign dist_sel    = (to_sel >= head_r) ? (to_sel - head_r) : (head_r - to_sel);
  assign total_sel   = total_r + {1'b0, dist_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      done_r   <= '0;
      served_r <= '0;
    end else begin
      if (cmd.start) begin
        done_r   <= '0;
        served_r <= '0;
      end else if (cmd.emit) begin
        done_r <= done_r + CW'(1);
        if (!empty_batch) begin
          served_r[best_idx_r] <= 1'b1;
        end
      end
      if (cmd.clear_batch) begin
        count_r <= '0;
      end else if (cmd.store && req_ok) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      head_r  <= head_start_r;
      total_r <= '0;
    end else if (cmd.emit) begin
      head_r  <= to_sel;
      total_r <= total_sel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      from_r  <= head_r;
      to_r    <= to_sel;
      dist_r  <= dist_sel;
      tot_r   <= total_sel;
      empty_r <= empty_batch;
      final_r <= sts.last_move;
    end
  end

  assign sts.scan_done = (scan_cnt_r == count_r) && !rd_v_r;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.last_move = empty_batch || ((done_r + CW'(1)) == count_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PadW{1'b0}}, tot_r, dist_r, to_r, from_r};
  assign out_tuser  = empty_r;
  assign out_tlast  = final_r;

endmodule

FILE: hw/rtl/look_disk_scheduler.sv
// LOOK disk scheduler: one request word per cycle while in_tready is high (low
// during scan and emit); on tlast, n moves follow. Each move is a memory scan of
// the n stored requests, a compare and an emit; an empty batch gives its single
// result. Next batch loads while the last result waits. Reset is synchronous,
// active low; the request memory is not cleared.
module look_disk_scheduler #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // request_cylinder
  input  logic                          in_tlast,   // batch_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // from_cylinder, to_cylinder, move_distance, running_total, zero pad
  output logic [lds_pkg::OutDataW-1:0]  out_tdata,
  output logic [0:0]                    out_tuser,  // batch_empty
  output logic                          out_tlast,  // final_move
  input  logic                          cfg_we,
  input  logic [lds_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lds_pkg::CfgW-1:0]      cfg_wdata
);

  lds_pkg::cmd_t cmd;
  lds_pkg::sts_t sts;

  lds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lds_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .req_cyl    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
